@@ design/assert_macros.svh @@
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset
`define RSI_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset
`define RSI_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/rsi_pkg.sv @@
// Shared types and constants of the rectilinear segment intersection unit
`default_nettype none

package rsi_pkg;

    // Field and register widths
    localparam int FIELD_BITS     = 32;
    localparam int TOL_BITS       = 16;
    localparam int COORD_BITS_DEF = 32;
    localparam logic [TOL_BITS-1:0] TOL_RESET = 16'd1;

    // Result codes, in order of priority
    typedef enum logic [2:0] {
        KIND_NONE     = 3'd0,
        KIND_CROSS    = 3'd1,
        KIND_OVERLAP  = 3'd2,
        KIND_TEE      = 3'd3,
        KIND_ENDPOINT = 3'd4
    } kind_t;

    // Input word: two segments, raw Q16.16 coordinates
    typedef struct packed {
        logic signed [FIELD_BITS-1:0] a_x1;
        logic signed [FIELD_BITS-1:0] a_y1;
        logic signed [FIELD_BITS-1:0] a_x2;
        logic signed [FIELD_BITS-1:0] a_y2;
        logic signed [FIELD_BITS-1:0] b_x1;
        logic signed [FIELD_BITS-1:0] b_y1;
        logic signed [FIELD_BITS-1:0] b_x2;
        logic signed [FIELD_BITS-1:0] b_y2;
    } seg_pair_t;

    // Result word
    typedef struct packed {
        logic  touches;
        kind_t touch_kind;
    } touch_result_t;

endpackage

`default_nettype wire

@@ design/rsi_if.sv @@
// Valid/ready channel interfaces for segment pairs and results
`default_nettype none

interface rsi_seg_if;
    logic                valid;
    logic                ready;
    rsi_pkg::seg_pair_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rsi_res_if;
    logic                    valid;
    logic                    ready;
    rsi_pkg::touch_result_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ design/rectilinear_segment_intersect_unit.sv @@
// Top level: input register, classifier and result register with valid/ready flow
//
// Usage:
//   seg_in  carries one word per segment pair: eight signed Q16.16 coordinates.
//   res_out carries one word per pair: touches and touch_kind.
//   cfg_we / cfg_wdata write the 16-bit tolerance; write only while no pair is
//   in flight. Reset sets the tolerance to 1 LSB.
// Path: a pair accepted into the input register reaches res_out through
//   two register stages (input register, result register).
// Throughput: one pair per cycle while res_out is not held; the classifier is a
//   single combinational pass between the two registers.
// Reset: both stages empty, seg_in.ready high, res_out.valid low.
// Stall: while res_out is held, the result stays stable and the input register
//   still takes one more pair; seg_in.ready drops only when both stages are full
//   and res_out.ready is low.
`default_nettype none

module rectilinear_segment_intersect_unit #(
    parameter int COORD_BITS = rsi_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    rsi_seg_if.sink                       seg_in,
    rsi_res_if.source                     res_out,
    input  logic                          cfg_we,
    input  logic [rsi_pkg::TOL_BITS-1:0]  cfg_wdata
);

    logic [rsi_pkg::TOL_BITS-1:0] tol_reg;
    logic [rsi_pkg::TOL_BITS-1:0] tol_next;
    logic                         s1_valid_reg;
    logic                         s1_valid_next;
    rsi_pkg::seg_pair_t           s1_data_reg;
    logic                         s2_valid_reg;
    logic                         s2_valid_next;
    rsi_pkg::touch_result_t       s2_res_reg;
    rsi_pkg::touch_result_t       res_calc;
    logic                         s1_load;
    logic                         s2_load;

    // Classifier between the two registers
    rsi_classify #(
        .COORD_BITS (COORD_BITS)
    ) u_classify (
        .seg (s1_data_reg),
        .tol (tol_reg),
        .res (res_calc)
    );

    // Flow control
    always_comb
    begin
        s2_load       = s1_valid_reg && (!s2_valid_reg || res_out.ready);
        s1_load       = seg_in.valid && seg_in.ready;
        s1_valid_next = s1_load || (s1_valid_reg && !s2_load);
        s2_valid_next = s2_load || (s2_valid_reg && !res_out.ready);
        tol_next      = cfg_we ? cfg_wdata : tol_reg;
    end

    assign seg_in.ready  = !s1_valid_reg || !s2_valid_reg || res_out.ready;
    assign res_out.valid = s2_valid_reg;
    assign res_out.data  = s2_res_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg      <= rsi_pkg::TOL_RESET;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            tol_reg      <= tol_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s1_load)
            s1_data_reg <= seg_in.data;
        if (s2_load)
            s2_res_reg <= res_calc;
    end

endmodule

`default_nettype wire

@@ design/rsi_classify.sv @@
// Combinational classifier: segment geometry and the four touch rules
`default_nettype none

module rsi_classify #(
    parameter int COORD_BITS = rsi_pkg::COORD_BITS_DEF
) (
    input  rsi_pkg::seg_pair_t              seg,
    input  logic [rsi_pkg::TOL_BITS-1:0]    tol,
    output rsi_pkg::touch_result_t          res
);

    // Working width: holds a coordinate difference and a coordinate plus tolerance
    localparam int CalcW   = ((COORD_BITS > rsi_pkg::TOL_BITS + 1) ?
                              COORD_BITS : rsi_pkg::TOL_BITS + 1) + 2;
    localparam bit SignOn  = (COORD_BITS <= rsi_pkg::FIELD_BITS);
    localparam int SignIdx = SignOn ? COORD_BITS - 1 : rsi_pkg::FIELD_BITS - 1;

    typedef logic signed [CalcW-1:0] calc_t;

    typedef struct packed {
        calc_t x1;
        calc_t y1;
        calc_t x2;
        calc_t y2;
        calc_t xlo;
        calc_t xhi;
        calc_t ylo;
        calc_t yhi;
        logic  h;
        logic  v;
    } geom_t;

    // Take the low COORD_BITS of a field and sign-extend; wider settings see a zero top
    function automatic calc_t sext(input logic [rsi_pkg::FIELD_BITS-1:0] raw);
        logic [CalcW+rsi_pkg::FIELD_BITS-1:0] ext;
        calc_t                                 val;
        ext = {{CalcW{1'b0}}, raw};
        for (int i = 0; i < CalcW; i++) begin
            if (i < COORD_BITS)
                val[i] = ext[i];
            else
                val[i] = SignOn ? raw[SignIdx] : 1'b0;
        end
        return val;
    endfunction

    // |p - q| < t
    function automatic logic near_eq(input calc_t p, input calc_t q, input calc_t t);
        calc_t d;
        d = p - q;
        return (d < t) && (d > -t);
    endfunction

    // |p - q| > t
    function automatic logic far_off(input calc_t p, input calc_t q, input calc_t t);
        calc_t d;
        d = p - q;
        return (d > t) || (d < -t);
    endfunction

    // lo + t < p < hi - t
    function automatic logic strict_in(input calc_t p, input calc_t lo, input calc_t hi,
                                       input calc_t t);
        calc_t lo_m;
        calc_t hi_m;
        lo_m = lo + t;
        hi_m = hi - t;
        return (p > lo_m) && (p < hi_m);
    endfunction

    // lo - t <= p <= hi + t
    function automatic logic loose_in(input calc_t p, input calc_t lo, input calc_t hi,
                                      input calc_t t);
        calc_t lo_m;
        calc_t hi_m;
        lo_m = lo - t;
        hi_m = hi + t;
        return (p >= lo_m) && (p <= hi_m);
    endfunction

    // Extents and orientation of one segment
    function automatic geom_t mk_geom(input logic [rsi_pkg::FIELD_BITS-1:0] rx1,
                                      input logic [rsi_pkg::FIELD_BITS-1:0] ry1,
                                      input logic [rsi_pkg::FIELD_BITS-1:0] rx2,
                                      input logic [rsi_pkg::FIELD_BITS-1:0] ry2,
                                      input calc_t t);
        geom_t g;
        g.x1  = sext(rx1);
        g.y1  = sext(ry1);
        g.x2  = sext(rx2);
        g.y2  = sext(ry2);
        g.xlo = (g.x1 < g.x2) ? g.x1 : g.x2;
        g.xhi = (g.x1 > g.x2) ? g.x1 : g.x2;
        g.ylo = (g.y1 < g.y2) ? g.y1 : g.y2;
        g.yhi = (g.y1 > g.y2) ? g.y1 : g.y2;
        g.h   = near_eq(g.y1, g.y2, t);
        g.v   = near_eq(g.x1, g.x2, t);
        return g;
    endfunction

    // Endpoint (px, py) strictly inside perpendicular segment o
    function automatic logic tee(input calc_t px, input calc_t py, input geom_t o,
                                 input logic from_h, input calc_t t);
        logic hit;
        if (from_h == o.h)
            hit = 1'b0;
        else if (o.h)
            hit = !far_off(py, o.y1, t) && strict_in(px, o.xlo, o.xhi, t);
        else if (o.v)
            hit = !far_off(px, o.x1, t) && strict_in(py, o.ylo, o.yhi, t);
        else
            hit = 1'b0;
        return hit;
    endfunction

    // Endpoint (px, py) on segment s, within tolerance
    function automatic logic on_seg(input calc_t px, input calc_t py, input geom_t s,
                                    input calc_t t);
        logic hit;
        if (s.v)
            hit = !far_off(px, s.x1, t) && loose_in(py, s.ylo, s.yhi, t);
        else if (s.h)
            hit = !far_off(py, s.y1, t) && loose_in(px, s.xlo, s.xhi, t);
        else
            hit = 1'b0;
        return hit;
    endfunction

    calc_t          tol_c;
    geom_t          ga;
    geom_t          gb;
    logic           cross_hit;
    logic           overlap_hit;
    logic           tee_hit;
    logic           end_hit;
    rsi_pkg::kind_t kind;

    assign tol_c = calc_t'({{(CalcW - rsi_pkg::TOL_BITS){1'b0}}, tol});

    // Segment geometry
    always_comb
    begin
        ga = mk_geom(seg.a_x1, seg.a_y1, seg.a_x2, seg.a_y2, tol_c);
        gb = mk_geom(seg.b_x1, seg.b_y1, seg.b_x2, seg.b_y2, tol_c);
    end

    // Perpendicular crossing
    always_comb
    begin
        if ((ga.h && gb.h) || (ga.v && gb.v))
            cross_hit = 1'b0;
        else if (ga.h && gb.v)
            cross_hit = strict_in(gb.x1, ga.xlo, ga.xhi, tol_c) &&
                        strict_in(ga.y1, gb.ylo, gb.yhi, tol_c);
        else if (ga.v && gb.h)
            cross_hit = strict_in(ga.x1, gb.xlo, gb.xhi, tol_c) &&
                        strict_in(gb.y1, ga.ylo, ga.yhi, tol_c);
        else
            cross_hit = 1'b0;
    end

    // Collinear overlap
    always_comb
    begin
        if (ga.h && gb.h && near_eq(ga.y1, gb.y1, tol_c))
            overlap_hit = (ga.xlo < gb.xhi - tol_c) && (gb.xlo < ga.xhi - tol_c);
        else if (ga.v && gb.v && near_eq(ga.x1, gb.x1, tol_c))
            overlap_hit = (ga.ylo < gb.yhi - tol_c) && (gb.ylo < ga.yhi - tol_c);
        else
            overlap_hit = 1'b0;
    end

    // T-junction and endpoint contact
    always_comb
    begin
        tee_hit = ((ga.h || ga.v) &&
                   (tee(ga.x1, ga.y1, gb, ga.h, tol_c) || tee(ga.x2, ga.y2, gb, ga.h, tol_c))) ||
                  ((gb.h || gb.v) &&
                   (tee(gb.x1, gb.y1, ga, gb.h, tol_c) || tee(gb.x2, gb.y2, ga, gb.h, tol_c)));
        end_hit = on_seg(ga.x1, ga.y1, gb, tol_c) || on_seg(ga.x2, ga.y2, gb, tol_c) ||
                  on_seg(gb.x1, gb.y1, ga, tol_c) || on_seg(gb.x2, gb.y2, ga, tol_c);
    end

    // First rule that holds
    always_comb
    begin
        if (cross_hit)
            kind = rsi_pkg::KIND_CROSS;
        else if (overlap_hit)
            kind = rsi_pkg::KIND_OVERLAP;
        else if (tee_hit)
            kind = rsi_pkg::KIND_TEE;
        else if (end_hit)
            kind = rsi_pkg::KIND_ENDPOINT;
        else
            kind = rsi_pkg::KIND_NONE;
        res.touch_kind = kind;
        res.touches    = (kind != rsi_pkg::KIND_NONE);
    end

endmodule

`default_nettype wire

@@ design/rsi_checker.sv @@
// Port-level assertions for the segment intersection unit, with its bind
`default_nettype none
`include "assert_macros.svh"

module rsi_checker (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_ready,
    input  logic                    out_valid,
    input  logic                    out_ready,
    input  rsi_pkg::touch_result_t  out_data
);

    logic out_hold;
    logic in_take;
    logic out_free;
    logic kind_set;

    // Handshake terms
    assign out_hold = out_valid && !out_ready;
    assign in_take  = in_valid && in_ready;
    assign out_free = out_ready || !out_valid;
    assign kind_set = (out_data.touch_kind != rsi_pkg::KIND_NONE);

    // A held result word keeps its value
    `RSI_ASSERT_NXT(a_hold_stable, out_hold, out_valid && $stable(out_data), "held word changed")

    // touches agrees with the kind code
    `RSI_ASSERT_IMP(a_touch_kind, out_valid, out_data.touches == kind_set, "touches/kind disagree")

    // Input backpressure only when both stages are full and the output stalls
    `RSI_ASSERT_IMP(a_ready_cause, !in_ready, out_hold, "input stalled without output stall")

    // An accepted word whose output path is free once it sits in the input register reaches the result register
    `RSI_ASSERT_NXT(a_latency, in_take ##1 out_free, out_valid, "result missing after two cycles")

endmodule

bind rectilinear_segment_intersect_unit rsi_checker u_rsi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (seg_in.valid),
    .in_ready  (seg_in.ready),
    .out_valid (res_out.valid),
    .out_ready (res_out.ready),
    .out_data  (res_out.data)
);

`default_nettype wire
